// ===== hdl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the arctangent table for the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int unsigned CORDIC_STEPS_DEF   = 16;
  localparam int unsigned COMPONENT_BITS_DEF = 16;

  localparam int unsigned QW = 16;  // Q14 component
  localparam int unsigned PW = 32;  // Q28 product
  localparam int unsigned SW = 35;  // Q28 sums
  localparam int unsigned CW = 37;  // CORDIC x/y
  localparam int unsigned ZW = 34;  // Q30 angle
  localparam int unsigned NW = 57;  // Q56 radicand
  localparam int unsigned RW = 29;  // root bits
  localparam int unsigned AW = 16;  // output angle

  localparam int unsigned PROD_LAT = 2;
  localparam int unsigned SQ_LAT   = 2 + RW;
  localparam int unsigned CONV_LAT = 2;

  localparam logic signed [SW-1:0] ONE_Q28         = 35'sd268435456;
  localparam logic signed [ZW-1:0] PI_HALF_Q30     = 34'sd1686629713;
  localparam logic signed [31:0]   DEG_PER_RAD_Q24 = 32'sd961263669;
  localparam logic signed [63:0]   ANGLE_LIMIT     = 64'sd25736;

  typedef struct packed {
    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] cr;
    logic signed [SW-1:0] sp;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] cy;
  } sums_t;

  typedef struct packed {
    logic sat;
    logic neg;
  } sat_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/quaternion_to_euler_angles_unit.sv =====
// Pipeline: products, square root, CORDIC, then unit conversion.
// Throughput: one quaternion per cycle; the whole pipeline holds on stall.
// Reset: clears valid bits and selects radians; no clearing pass.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Quaternion to roll, pitch and yaw (Z-Y-X) in fixed point.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit #(
  parameter int unsigned CORDIC_STEPS   = qte_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [COMPONENT_BITS-1:0]     quat_w_i,
  input  logic [COMPONENT_BITS-1:0]     quat_x_i,
  input  logic [COMPONENT_BITS-1:0]     quat_y_i,
  input  logic [COMPONENT_BITS-1:0]     quat_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [qte_pkg::AW-1:0] roll_angle_o,
  output logic signed [qte_pkg::AW-1:0] pitch_angle_o,
  output logic signed [qte_pkg::AW-1:0] yaw_angle_o,
  output logic                          pitch_saturated_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);
  import qte_pkg::*;

  localparam int unsigned CL  = CORDIC_STEPS + 1;
  localparam int unsigned SDL = SQ_LAT + CL + CONV_LAT;
  localparam int unsigned LAT = PROD_LAT + SDL;

  logic                 en;
  logic                 unit_q;
  logic [LAT-1:0]       valid_q;
  sums_t                sums;
  sat_t                 sat;
  logic [RW-1:0]        root;
  sums_t                dl_q [SQ_LAT];
  sat_t                 sd_q [SDL];
  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z, pitch_sel;
  sat_t                 sat_tap;

  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unit_q <= cfg_data_i;
      end
      if (en) begin
        valid_q <= {valid_q[LAT-2:0], in_valid_i};
      end
    end
  end

  assign out_valid_o = valid_q[LAT-1];

  qte_prod #(.COMPONENT_BITS(COMPONENT_BITS)) u_prod (
    .clk_i    (clk_i),
    .en_i     (en),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .sums_o   (sums),
    .sat_o    (sat)
  );

  qte_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sp_i   (sums.sp),
    .root_o (root)
  );

  // align roll/yaw terms and the pitch sine with the square root, and saturation with the CORDIC and conversion outputs
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= sums;
      for (int k = 1; k < SQ_LAT; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
      sd_q[0] <= sat;
      for (int k = 1; k < SDL; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(dl_q[SQ_LAT-1].sr)),
    .x_i   (CW'(dl_q[SQ_LAT-1].cr)),
    .z_o   (roll_z)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(dl_q[SQ_LAT-1].sp)),
    .x_i   (CW'($signed({1'b0, root}))),
    .z_o   (pitch_z)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(dl_q[SQ_LAT-1].sy)),
    .x_i   (CW'(dl_q[SQ_LAT-1].cy)),
    .z_o   (yaw_z)
  );

  assign sat_tap   = sd_q[SQ_LAT + CL - 1];
  assign pitch_sel = !sat_tap.sat ? pitch_z :
                     (sat_tap.neg ? -PI_HALF_Q30 : PI_HALF_Q30);

  qte_conv u_conv_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .unit_i  (unit_q),
    .angle_i (roll_z),
    .angle_o (roll_angle_o)
  );

  qte_conv u_conv_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .unit_i  (unit_q),
    .angle_i (pitch_sel),
    .angle_o (pitch_angle_o)
  );

  qte_conv u_conv_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .unit_i  (unit_q),
    .angle_i (yaw_z),
    .angle_o (yaw_angle_o)
  );

  assign pitch_saturated_o = sd_q[SDL-1].sat;

endmodule

// ===== hdl/qte_prod.sv =====
// ----------------------------------------------------------------------------
// qte_prod
// Scales components to Q14, forms the Q28 products, then the five sums and
// the pitch saturation flag. Two register stages.
// ----------------------------------------------------------------------------
module qte_prod #(
  parameter int unsigned COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [COMPONENT_BITS-1:0] quat_w_i,
  input  logic [COMPONENT_BITS-1:0] quat_x_i,
  input  logic [COMPONENT_BITS-1:0] quat_y_i,
  input  logic [COMPONENT_BITS-1:0] quat_z_i,
  output qte_pkg::sums_t            sums_o,
  output qte_pkg::sat_t             sat_o
);
  import qte_pkg::*;

  logic [COMPONENT_BITS-1:0] raw [4];
  logic signed [QW-1:0]      q   [4];

  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  sums_t                sums_d, sums_q;
  sat_t                 sat_d, sat_q;

  assign raw[0] = quat_w_i;
  assign raw[1] = quat_x_i;
  assign raw[2] = quat_y_i;
  assign raw[3] = quat_z_i;

  for (genvar c = 0; c < 4; c++) begin : g_scale
    if (COMPONENT_BITS > QW) begin : g_wide
      assign q[c] = QW'($signed(raw[c]) >>> (COMPONENT_BITS - QW));
    end else if (COMPONENT_BITS < QW) begin : g_narrow
      assign q[c] = {raw[c], {(QW - COMPONENT_BITS){1'b0}}};
    end else begin : g_same
      assign q[c] = raw[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= q[0] * q[1];
      yz_q <= q[2] * q[3];
      xx_q <= q[1] * q[1];
      yy_q <= q[2] * q[2];
      wy_q <= q[0] * q[2];
      zx_q <= q[3] * q[1];
      wz_q <= q[0] * q[3];
      xy_q <= q[1] * q[2];
      zz_q <= q[3] * q[3];
    end
  end

  always_comb begin
    sums_d.sr = (SW'(wx_q) + SW'(yz_q)) <<< 1;
    sums_d.cr = ONE_Q28 - ((SW'(xx_q) + SW'(yy_q)) <<< 1);
    sums_d.sp = (SW'(wy_q) - SW'(zx_q)) <<< 1;
    sums_d.sy = (SW'(wz_q) + SW'(xy_q)) <<< 1;
    sums_d.cy = ONE_Q28 - ((SW'(yy_q) + SW'(zz_q)) <<< 1);
    sat_d.sat = (sums_d.sp >= ONE_Q28) || (sums_d.sp <= -ONE_Q28);
    sat_d.neg = sums_d.sp[SW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sums_q <= sums_d;
      sat_q  <= sat_d;
    end
  end

  assign sums_o = sums_q;
  assign sat_o  = sat_q;

endmodule

// ===== hdl/qte_sqrt.sv =====
// ----------------------------------------------------------------------------
// qte_sqrt
// Forms 1 - s^2 in Q56 and takes its floor square root, one result bit per
// stage.
// ----------------------------------------------------------------------------
module qte_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [qte_pkg::SW-1:0] sp_i,
  output logic [qte_pkg::RW-1:0]       root_o
);
  import qte_pkg::*;

  logic signed [28:0] sm;
  logic [NW-1:0]      sq_q, rest_q;
  logic [NW-1:0]      n_q [RW];
  logic [NW-1:0]      r_q [RW];

  assign sm = sp_i[28:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= NW'(sm * sm);
      rest_q <= (NW'(1) << 56) - sq_q;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (RW - 1 - k));
    logic [NW-1:0] n_in, r_in, t;
    if (k == 0) begin : g_first
      assign n_in = rest_q;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end
    assign t = r_in + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_in >= t) begin
          n_q[k] <= n_in - t;
          r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          n_q[k] <= n_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[RW-1][RW-1:0];

endmodule

// ===== hdl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC atan2 in Q30 radians: quadrant fold, then one
// micro-rotation per stage.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int unsigned STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [qte_pkg::CW-1:0] y_i,
  input  logic signed [qte_pkg::CW-1:0] x_i,
  output logic signed [qte_pkg::ZW-1:0] z_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_q [STEPS+1];
  logic signed [CW-1:0] y_q [STEPS+1];
  logic signed [ZW-1:0] z_q [STEPS+1];
  logic                 zero_q [STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          z_q[0] <= PI_HALF_Q30;
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          z_q[0] <= -PI_HALF_Q30;
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_q30(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_q30(5'(i));
        end
      end
    end
  end

  assign z_o = zero_q[STEPS] ? '0 : z_q[STEPS];

endmodule

// ===== hdl/qte_conv.sv =====
// ----------------------------------------------------------------------------
// qte_conv
// Converts a Q30 radian angle to Q13 radians or Q7 degrees, rounds and
// clamps. Two stages; the second is the output register.
// ----------------------------------------------------------------------------
module qte_conv (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          unit_i,
  input  logic signed [qte_pkg::ZW-1:0] angle_i,
  output logic signed [qte_pkg::AW-1:0] angle_o
);
  import qte_pkg::*;

  logic signed [63:0]   prod_q;
  logic signed [ZW-1:0] a_q;
  logic signed [63:0]   v;
  logic signed [AW-1:0] angle_d, angle_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(angle_i * DEG_PER_RAD_Q24);
      a_q    <= angle_i;
    end
  end

  always_comb begin
    if (unit_i) begin
      v = (prod_q + (64'sd1 <<< 46)) >>> 47;
    end else begin
      v = (64'(a_q) + (64'sd1 <<< 16)) >>> 17;
    end
    if (v > ANGLE_LIMIT) begin
      angle_d = AW'(ANGLE_LIMIT);
    end else if (v < -ANGLE_LIMIT) begin
      angle_d = AW'(-ANGLE_LIMIT);
    end else begin
      angle_d = AW'(v);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

// ===== dv/quaternion_to_euler_angles_unit_test.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit_test
// Drives quaternions through the Euler angle pipeline in both angle units and
// compares every roll, pitch, yaw and saturation flag with a bit-exact
// fixed-point predictor built into this bench. Random gaps on both sides and
// one long output stall exercise the pipeline hold.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit_test;
  import qte_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 36;

  typedef struct {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
    logic sat;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [AW-1:0] roll_angle_o, pitch_angle_o, yaw_angle_o;
  logic pitch_saturated_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  angles_t expected_angles[$];
  logic degrees_mode;
  int mismatches = 0;
  bit hold_output = 1'b0;
  int hold_cycles = 0;

  always #5 clk_i = ~clk_i;

  quaternion_to_euler_angles_unit dut (.*);

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arctan2_q30(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(PI_HALF_Q30);
      end else begin
        t = x; x = -y; y = t; z = -longint'(PI_HALF_Q30);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic logic signed [AW-1:0] to_unit(longint a);
    longint v;
    if (degrees_mode) v = sra(a * 64'sd961263669 + (64'sd1 <<< 46), 47);
    else v = sra(a + (64'sd1 <<< 16), 17);
    if (v > 25736) v = 25736;
    if (v < -25736) v = -25736;
    return AW'(v);
  endfunction

  function automatic angles_t euler_of(logic [15:0] qw, logic [15:0] qx,
                                       logic [15:0] qy, logic [15:0] qz);
    longint w, x, y, z, sr, cr, sp, sy, cy, p, one;
    angles_t r;
    w = longint'($signed(qw));
    x = longint'($signed(qx));
    y = longint'($signed(qy));
    z = longint'($signed(qz));
    one = 64'sd1 <<< 28;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    r.sat = 1'b0;
    if (sp >= one) begin
      p = longint'(PI_HALF_Q30); r.sat = 1'b1;
    end else if (sp <= -one) begin
      p = -longint'(PI_HALF_Q30); r.sat = 1'b1;
    end else begin
      p = arctan2_q30(sp, int_sqrt(longint'((64'd1 << 56) - longint'(sp * sp))));
    end
    r.roll = to_unit(arctan2_q30(sr, cr));
    r.pitch = to_unit(p);
    r.yaw = to_unit(arctan2_q30(sy, cy));
    return r;
  endfunction

  // valid stays high into the next call; it drops only for a gap or a drain
  task automatic send_quat(logic [15:0] qw, logic [15:0] qx,
                           logic [15:0] qy, logic [15:0] qz, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i <= qw; quat_x_i <= qx; quat_y_i <= qy; quat_z_i <= qz;
    expected_angles.push_back(euler_of(qw, qx, qy, qz));
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_angles.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_unit(logic deg);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= deg;
    do @(posedge clk_i); while (!cfg_ready_o);
    degrees_mode = deg;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random quaternion: components within +/-8192, full-range random, or +/-11585
  task automatic send_random(bit gaps = 1);
    logic [15:0] c[4];
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      if (mode < 6) c[k] = 16'($signed($urandom_range(0, 16384)) - 8192);
      else if (mode < 8) c[k] = 16'($urandom);
      else c[k] = 16'(($urandom_range(0, 1) ? 11585 : -11585));
    end
    send_quat(c[0], c[1], c[2], c[3], gaps);
  endtask

  task automatic test_directed();
    send_quat(16'd16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11585, 0, 11586, 0);
    send_quat(0, 16'd16384, 0, 0);
    send_quat(0, 0, 0, 16'd16384);
    send_quat(0, 0, 16'd16384, 0);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 0, -11585);
    send_quat(16'hffff, 16'h5555, 16'haaaa, 16'h0001);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(16'd32767, 0, 0, 0);
  endtask

  task automatic test_random_radians();
    repeat (500) send_random();
  endtask

  task automatic test_random_degrees();
    repeat (500) send_random();
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    hold_output = 1'b1;
    repeat (150) send_random(0);
  endtask

  always @(posedge clk_i) begin
    angles_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word");
      end else begin
        e = expected_angles.pop_front();
        if (roll_angle_o !== e.roll || pitch_angle_o !== e.pitch ||
            yaw_angle_o !== e.yaw || pitch_saturated_o !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                     e.roll, e.pitch, e.yaw, e.sat, roll_angle_o,
                     pitch_angle_o, yaw_angle_o, pitch_saturated_o);
        end
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_output = 1'b0;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, 7);
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    degrees_mode = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_unit(1'b0);
    test_directed();
    test_random_radians();
    drain();
    write_unit(1'b1);
    test_directed();
    test_random_degrees();
    test_backpressure();
    drain();
    write_unit(1'b0);
    repeat (40) send_random();
    drain();
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/qte_pkg.sv
hdl/qte_prod.sv
hdl/qte_sqrt.sv
hdl/qte_cordic.sv
hdl/qte_conv.sv
hdl/quaternion_to_euler_angles_unit.sv
dv/quaternion_to_euler_angles_unit_test.sv
